FILE: rtl/core/view_matrix_from_look_at_top_defines.svh
// assertion helpers used by the block's top-level rtl
`ifndef VIEW_MATRIX_FROM_LOOK_AT_TOP_DEFINES_SVH
`define VIEW_MATRIX_FROM_LOOK_AT_TOP_DEFINES_SVH

// clocked on clk_i, quiet while rst_ni is low
`define VMLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// plain implication form
`define VMLA_ASSERT_IMP(lbl, ante, cons, msg) \
  `VMLA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/vmla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vmla_pkg;

  // normalizer: magnitude, three align stages, square, sum,
  // square-root steps, numerator setup, divide steps, sign
  localparam int unsigned SQ_STEPS  = 31;
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned NRM_LAT   = 1 + 3 + 1 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1;

  // input register, normalizer, cross, normalizer, cross, round, dot, sum
  localparam int unsigned LAT = 2 * NRM_LAT + 8;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] row0_x;
    logic signed [31:0] row0_y;
    logic signed [31:0] row0_z;
    logic signed [31:0] row1_x;
    logic signed [31:0] row1_y;
    logic signed [31:0] row1_z;
    logic signed [31:0] row2_x;
    logic signed [31:0] row2_y;
    logic signed [31:0] row2_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/vmla_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vmla_in_if import vmla_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vmla_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vmla_out_if import vmla_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vmla_norm.sv
`timescale 1ns / 1ps
`default_nettype none
module vmla_norm import vmla_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2:0][63:0] vec_i,
  output logic [2:0][31:0] unit_o
);

  // shift all words left by k when the or-word has its top k bits clear
  function automatic logic [3:0][62:0] align_by(input logic [3:0][62:0] w,
                                                input int unsigned k);
    logic [3:0][62:0] r;
    r = w;
    if ((w[3] >> (63 - k)) == 63'd0) begin
      for (int j = 0; j < 4; j++) r[j] = w[j] << k;
    end
    return r;
  endfunction

  logic [2:0][63:0] abs_w;
  logic [3:0][62:0] al_q [4];
  logic [2:0]       ng_q [4];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      abs_w[j] = vec_i[j][63] ? (~vec_i[j] + 64'd1) : vec_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) al_q[0][j] <= abs_w[j][62:0];
      al_q[0][3] <= abs_w[0][62:0] | abs_w[1][62:0] | abs_w[2][62:0];
      ng_q[0]    <= {vec_i[2][63], vec_i[1][63], vec_i[0][63]};
      al_q[1]    <= align_by(align_by(al_q[0], 32), 16);
      al_q[2]    <= align_by(align_by(al_q[1], 8), 4);
      al_q[3]    <= align_by(align_by(al_q[2], 2), 1);
      ng_q[1]    <= ng_q[0];
      ng_q[2]    <= ng_q[1];
      ng_q[3]    <= ng_q[2];
    end
  end

  // largest magnitude now sits at bit 62; keep a 30-bit window
  logic [2:0][29:0] mp_w;
  logic [2:0][59:0] sq_q;
  logic [2:0][29:0] sm_q;
  logic [2:0]       sn_q;
  logic             sz_q;

  always_comb begin
    for (int j = 0; j < 3; j++) mp_w[j] = al_q[3][j][62:33];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) sq_q[j] <= mp_w[j] * mp_w[j];
      sm_q <= mp_w;
      sn_q <= ng_q[3];
      sz_q <= ~al_q[3][3][62];
    end
  end

  // square root, one result bit per stage
  logic [61:0]      sx_q    [SQ_STEPS+1];
  logic [31:0]      srem_q  [SQ_STEPS+1];
  logic [30:0]      sroot_q [SQ_STEPS+1];
  logic [2:0][29:0] cm_q    [SQ_STEPS+1];
  logic [2:0]       cn_q    [SQ_STEPS+1];
  logic             cz_q    [SQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0]    <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      cm_q[0]    <= sm_q;
      cn_q[0]    <= sn_q;
      cz_q[0]    <= sz_q;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [33:0] rn;
    logic [32:0] tr;
    logic [33:0] df;
    logic        ge;

    assign rn = {srem_q[k], sx_q[k][61:60]};
    assign tr = {sroot_q[k], 2'b01};
    assign ge = rn >= {1'b0, tr};
    assign df = rn - {1'b0, tr};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[k+1]  <= ge ? df[31:0] : rn[31:0];
        sroot_q[k+1] <= {sroot_q[k][29:0], ge};
        sx_q[k+1]    <= {sx_q[k][59:0], 2'b00};
        cm_q[k+1]    <= cm_q[k];
        cn_q[k+1]    <= cn_q[k];
        cz_q[k+1]    <= cz_q[k];
      end
    end
  end

  // rounded quotient: numerator is m * 2^30 + r/2
  logic [2:0][60:0] nm_w;
  logic [2:0][30:0] drem_q [DIV_STEPS+1];
  logic [2:0][30:0] dn_q   [DIV_STEPS+1];
  logic [30:0]      dr_q   [DIV_STEPS+1];
  logic [2:0]       dng_q  [DIV_STEPS+1];
  logic             dz_q   [DIV_STEPS+1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nm_w[j] = {1'b0, cm_q[SQ_STEPS][j], 30'd0} + 61'(sroot_q[SQ_STEPS] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        drem_q[0][j] <= {1'b0, nm_w[j][60:31]};
        dn_q[0][j]   <= nm_w[j][30:0];
      end
      dr_q[0]  <= sroot_q[SQ_STEPS];
      dng_q[0] <= cn_q[SQ_STEPS];
      dz_q[0]  <= cz_q[SQ_STEPS];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [2:0][31:0] tt;
    logic [2:0][31:0] df;
    logic [2:0]       ge;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        tt[j] = {drem_q[k][j], dn_q[k][j][30]};
        ge[j] = tt[j] >= {1'b0, dr_q[k]};
        df[j] = tt[j] - {1'b0, dr_q[k]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 3; j++) begin
          drem_q[k+1][j] <= ge[j] ? df[j][30:0] : tt[j][30:0];
          dn_q[k+1][j]   <= {dn_q[k][j][29:0], ge[j]};
        end
        dr_q[k+1]  <= dr_q[k];
        dng_q[k+1] <= dng_q[k];
        dz_q[k+1]  <= dz_q[k];
      end
    end
  end

  logic [2:0][31:0] unit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        if (dz_q[DIV_STEPS]) begin
          unit_q[j] <= '0;
        end else if (dng_q[DIV_STEPS][j]) begin
          unit_q[j] <= ~{1'b0, dn_q[DIV_STEPS][j]} + 32'd1;
        end else begin
          unit_q[j] <= {1'b0, dn_q[DIV_STEPS][j]};
        end
      end
    end
  end

  assign unit_o = unit_q;

endmodule
`default_nettype wire

FILE: rtl/core/view_matrix_from_look_at_top.sv
// Look-at camera: takes eye, target and up hint in signed Q16.16 and returns the
// rotation rows (side, new up, negated forward) in Q2.30 plus the translation in
// saturated Q16.16. One camera is accepted every cycle unless the skid stage is
// full. A camera passes 148 pipeline stages, the first one loaded at the edge
// that takes its input, then the output register; most of that depth is the two
// vector normalizers, each 70 stages deep with 31 square-root steps and 31 divide
// steps. A skid stage behind the output register lets one more word land while
// the consumer stalls; the whole pipe holds while the skid stage is full.
`timescale 1ns / 1ps
`default_nettype none
`include "view_matrix_from_look_at_top_defines.svh"
module view_matrix_from_look_at_top import vmla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vmla_in_if.sink    in_i,
  vmla_out_if.source out_o
);

  localparam int unsigned FL = NRM_LAT + 2;
  localparam int unsigned EL = 2 * NRM_LAT + 2;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh07fffffff) begin
      r = 32'h7fffffff;
    end else if (v < -36'sh080000000) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic             adv;
  logic [LAT-1:0]   vld_q;
  logic             skid_v_q;
  logic             out_v_q;
  out_item_t        out_q;
  out_item_t        skid_q;
  out_item_t        res_w;

  assign adv        = ~skid_v_q;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // input stage
  logic [2:0][31:0] eye_w, tgt_w, up_w;
  logic [2:0][63:0] d_q;
  logic [2:0][31:0] up_q, eye_q;
  logic [2:0][32:0] d33_w;

  assign eye_w = {in_i.data.eye_z, in_i.data.eye_y, in_i.data.eye_x};
  assign tgt_w = {in_i.data.target_z, in_i.data.target_y, in_i.data.target_x};
  assign up_w  = {in_i.data.upward_z, in_i.data.upward_y, in_i.data.upward_x};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d33_w[j] = {tgt_w[j][31], tgt_w[j]} - {eye_w[j][31], eye_w[j]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) d_q[j] <= {{31{d33_w[j][32]}}, d33_w[j]};
      up_q  <= up_w;
      eye_q <= eye_w;
    end
  end

  // forward
  logic [2:0][31:0] f_w;

  vmla_norm u_norm_fwd (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (d_q),
    .unit_o (f_w)
  );

  logic [2:0][31:0] ul_q [NRM_LAT];
  logic [2:0][31:0] el_q [EL];
  logic [2:0][31:0] fl_q [FL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ul_q[0] <= up_q;
      for (int k = 1; k < NRM_LAT; k++) ul_q[k] <= ul_q[k-1];
      el_q[0] <= eye_q;
      for (int k = 1; k < EL; k++) el_q[k] <= el_q[k-1];
      fl_q[0] <= f_w;
      for (int k = 1; k < FL; k++) fl_q[k] <= fl_q[k-1];
    end
  end

  // side = forward x up
  logic signed [63:0] sp_q [6];
  logic        [2:0][63:0] sraw_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sp_q[0] <= $signed(f_w[1]) * $signed(ul_q[NRM_LAT-1][2]);
      sp_q[1] <= $signed(f_w[2]) * $signed(ul_q[NRM_LAT-1][1]);
      sp_q[2] <= $signed(f_w[2]) * $signed(ul_q[NRM_LAT-1][0]);
      sp_q[3] <= $signed(f_w[0]) * $signed(ul_q[NRM_LAT-1][2]);
      sp_q[4] <= $signed(f_w[0]) * $signed(ul_q[NRM_LAT-1][1]);
      sp_q[5] <= $signed(f_w[1]) * $signed(ul_q[NRM_LAT-1][0]);
      sraw_q[0] <= sp_q[0] - sp_q[1];
      sraw_q[1] <= sp_q[2] - sp_q[3];
      sraw_q[2] <= sp_q[4] - sp_q[5];
    end
  end

  logic [2:0][31:0] s_w;

  vmla_norm u_norm_side (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (sraw_q),
    .unit_o (s_w)
  );

  // new up = side x forward, then round and saturate
  logic signed [63:0] up_p_q [6];
  logic signed [63:0] ur_q [3];
  logic [2:0][31:0]   s4_q, f4_q, e4_q, s5_q, f5_q, e5_q, s6_q, f6_q, e6_q;
  logic [2:0][31:0]   r1_q;
  logic [2:0][63:0]   umag_w;
  logic [2:0][33:0]   uq_w;
  logic [2:0][31:0]   r1_w;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      umag_w[j] = ur_q[j][63] ? (~ur_q[j] + 64'd1) : ur_q[j];
      uq_w[j]   = 34'((umag_w[j] + 64'd536870912) >> 30);
      if (!ur_q[j][63]) begin
        r1_w[j] = (uq_w[j] > 34'h07fffffff) ? 32'h7fffffff : uq_w[j][31:0];
      end else begin
        r1_w[j] = (uq_w[j] > 34'h080000000) ? 32'h80000000 : ~uq_w[j][31:0] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      up_p_q[0] <= $signed(s_w[1]) * $signed(fl_q[FL-1][2]);
      up_p_q[1] <= $signed(s_w[2]) * $signed(fl_q[FL-1][1]);
      up_p_q[2] <= $signed(s_w[2]) * $signed(fl_q[FL-1][0]);
      up_p_q[3] <= $signed(s_w[0]) * $signed(fl_q[FL-1][2]);
      up_p_q[4] <= $signed(s_w[0]) * $signed(fl_q[FL-1][1]);
      up_p_q[5] <= $signed(s_w[1]) * $signed(fl_q[FL-1][0]);
      s4_q <= s_w;
      f4_q <= fl_q[FL-1];
      e4_q <= el_q[EL-1];
      ur_q[0] <= up_p_q[0] - up_p_q[1];
      ur_q[1] <= up_p_q[2] - up_p_q[3];
      ur_q[2] <= up_p_q[4] - up_p_q[5];
      s5_q <= s4_q;
      f5_q <= f4_q;
      e5_q <= e4_q;
      r1_q <= r1_w;
      s6_q <= s5_q;
      f6_q <= f5_q;
      e6_q <= e5_q;
    end
  end

  // translation: each row dotted with the negated eye
  logic [2:0][2:0][31:0] rw_w, rw7_q, rw8_q;
  logic [2:0][32:0]      neye_w;
  logic signed [64:0]    dp_q [3][3];
  logic signed [65:0]    ds_q [3];
  logic signed [65:0]    dr_w [3];

  always_comb begin
    rw_w[0] = s6_q;
    rw_w[1] = r1_q;
    for (int j = 0; j < 3; j++) begin
      rw_w[2][j] = ~f6_q[j] + 32'd1;
      neye_w[j]  = ~{e6_q[j][31], e6_q[j]} + 33'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          dp_q[k][j] <= $signed(rw_w[k][j]) * $signed(neye_w[j]);
        end
        ds_q[k] <= 66'(dp_q[k][0]) + 66'(dp_q[k][1]) + 66'(dp_q[k][2]);
      end
      rw7_q <= rw_w;
      rw8_q <= rw7_q;
    end
  end

  // round half up, drop 30 fraction bits
  always_comb begin
    for (int k = 0; k < 3; k++) dr_w[k] = ds_q[k] + 66'sd536870912;
  end

  always_comb begin
    res_w.row0_x  = rw8_q[0][0];
    res_w.row0_y  = rw8_q[0][1];
    res_w.row0_z  = rw8_q[0][2];
    res_w.row1_x  = rw8_q[1][0];
    res_w.row1_y  = rw8_q[1][1];
    res_w.row1_z  = rw8_q[1][2];
    res_w.row2_x  = rw8_q[2][0];
    res_w.row2_y  = rw8_q[2][1];
    res_w.row2_z  = rw8_q[2][2];
    res_w.shift_x = sat32($signed(dr_w[0][65:30]));
    res_w.shift_y = sat32($signed(dr_w[1][65:30]));
    res_w.shift_z = sat32($signed(dr_w[2][65:30]));
  end

  // output register with one skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= vld_q[LAT-1];
      end
    end else if (adv && vld_q[LAT-1]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      out_q <= skid_v_q ? skid_q : res_w;
    end
    if (!skid_v_q) begin
      skid_q <= res_w;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  `VMLA_ASSERT_IMP(a_skid_needs_out, skid_v_q, out_v_q, "skid word without output word")
  `VMLA_ASSERT(a_accept_enters, (in_i.valid && in_i.ready) |=> vld_q[0], "accepted word lost")
  `VMLA_ASSERT(a_tail_lands, (adv && vld_q[LAT-1]) |=> out_v_q, "finished word dropped")
  `VMLA_ASSERT(a_hold_on_stall, !adv |=> $stable(vld_q), "pipe moved while stalled")

endmodule
`default_nettype wire

FILE: tb/sv/vmla_checker.sv
`timescale 1ns / 1ps
module vmla_checker import vmla_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  vmla_in_if   cam_mon,
  vmla_out_if  mat_mon,
  output int   mismatches_o,
  output int   pending_o,
  output int   matrices_o
);

  typedef longint vec3_t [3];

  out_item_t matrix_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale so the largest magnitude sits in [2^29, 2^30), then divide by the length
  function automatic vec3_t unit_q30(vec3_t v);
    vec3_t       o;
    logic [63:0] m [3];
    logic [63:0] top, acc, r, q;
    int          len;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) return '{0, 0, 0};
    len = 0;
    while (len < 64 && (top >> len) != 0) len++;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) m[i] = m[i] >> (len - 30);
      else m[i] = m[i] << (30 - len);
      acc += m[i] * m[i];
    end
    r = int_sqrt(acc);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (r >> 1)) / r;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return o;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // half away from zero
  function automatic longint round_q60_to_q30(longint v);
    logic [63:0] q;
    q = ((v < 0 ? 64'(-v) : 64'(v)) + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  // exact sum, then half toward plus infinity is a floor after adding half
  function automatic longint shift_term(vec3_t row, vec3_t neye);
    logic signed [127:0] acc;
    longint              p;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      p = row[i] * neye[i];
      acc += p;
    end
    acc = (acc + (128'sd1 <<< 29)) >>> 30;
    if (acc > 128'sd2147483647) return 64'sd2147483647;
    if (acc < -128'sd2147483648) return -64'sd2147483648;
    return longint'(acc);
  endfunction

  function automatic out_item_t look_at_matrix(in_item_t c);
    vec3_t     neye, fwd, side, upv, up_hint, dir;
    out_item_t o;
    neye    = '{-longint'(c.eye_x), -longint'(c.eye_y), -longint'(c.eye_z)};
    dir     = '{longint'(c.target_x) + neye[0], longint'(c.target_y) + neye[1],
                longint'(c.target_z) + neye[2]};
    up_hint = '{longint'(c.upward_x), longint'(c.upward_y), longint'(c.upward_z)};
    fwd  = unit_q30(dir);
    side = unit_q30(cross3(fwd, up_hint));
    upv  = cross3(side, fwd);
    for (int i = 0; i < 3; i++) begin
      upv[i] = clamp32(round_q60_to_q30(upv[i]));
      fwd[i] = -fwd[i];
    end
    o.row0_x = side[0]; o.row0_y = side[1]; o.row0_z = side[2];
    o.row1_x = upv[0];  o.row1_y = upv[1];  o.row1_z = upv[2];
    o.row2_x = fwd[0];  o.row2_y = fwd[1];  o.row2_z = fwd[2];
    o.shift_x = shift_term(side, neye);
    o.shift_y = shift_term(upv, neye);
    o.shift_z = shift_term(fwd, neye);
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      mismatches_o++;
    end
  endfunction

  initial begin
    mismatches_o = 0;
    matrices_o = 0;
  end

  assign pending_o = matrix_q.size();

  always @(posedge clk_i) begin
    out_item_t e, a;
    if (rst_ni) begin
      if (cam_mon.valid && cam_mon.ready) matrix_q.push_back(look_at_matrix(cam_mon.data));
      if (mat_mon.valid && mat_mon.ready) begin
        a = mat_mon.data;
        matrices_o++;
        if (matrix_q.size() == 0) begin
          $error("matrix word with no camera waiting");
          mismatches_o++;
        end else begin
          e = matrix_q.pop_front();
          check_field("row0_x", e.row0_x, a.row0_x);
          check_field("row0_y", e.row0_y, a.row0_y);
          check_field("row0_z", e.row0_z, a.row0_z);
          check_field("row1_x", e.row1_x, a.row1_x);
          check_field("row1_y", e.row1_y, a.row1_y);
          check_field("row1_z", e.row1_z, a.row1_z);
          check_field("row2_x", e.row2_x, a.row2_x);
          check_field("row2_y", e.row2_y, a.row2_y);
          check_field("row2_z", e.row2_z, a.row2_z);
          check_field("shift_x", e.shift_x, a.shift_x);
          check_field("shift_y", e.shift_y, a.shift_y);
          check_field("shift_z", e.shift_z, a.shift_z);
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import vmla_pkg::*;

  localparam int MAXP = 2147483647;
  localparam int MINN = -MAXP - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatches, pending, matrices, cameras;
  int   tx_idle, rx_idle, phase;
  logic held;

  vmla_in_if  cam_ch ();
  vmla_out_if mat_ch ();

  view_matrix_from_look_at_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cam_ch),
    .out_o  (mat_ch)
  );

  vmla_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cam_mon      (cam_ch),
    .mat_mon      (mat_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .matrices_o   (matrices)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_camera(in_item_t c);
    while ($urandom_range(99) < tx_idle) begin
      cam_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cam_ch.valid <= 1'b1;
    cam_ch.data  <= c;
    cameras++;
    do @(posedge clk_i); while (!cam_ch.ready);
    @(negedge clk_i);
  endtask

  function automatic in_item_t cam(int ex, ey, ez, tx, ty, tz, ux, uy, uz);
    in_item_t c;
    c = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    return c;
  endfunction

  function automatic int near_val();
    return int'($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  function automatic in_item_t random_camera();
    int       kind, k;
    int       d [3];
    in_item_t c;
    kind = $urandom_range(99);
    c = cam(near_val(), near_val(), near_val(), near_val(), near_val(), near_val(),
            near_val(), near_val(), near_val());
    if (kind < 20) begin
      c = cam($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
    end else if (kind < 32) begin
      c.target_x = c.eye_x; c.target_y = c.eye_y; c.target_z = c.eye_z;
    end else if (kind < 44) begin
      // up hint along the view direction, either sense
      for (int i = 0; i < 3; i++) d[i] = int'($urandom_range(4095)) - 2048;
      k = int'($urandom_range(64)) - 32;
      c.target_x = c.eye_x + d[0]; c.target_y = c.eye_y + d[1]; c.target_z = c.eye_z + d[2];
      c.upward_x = d[0] * k; c.upward_y = d[1] * k; c.upward_z = d[2] * k;
    end else if (kind < 52) begin
      c.upward_x = 0; c.upward_y = 0; c.upward_z = 0;
    end else if (kind < 62) begin
      c.eye_x = $urandom_range(1) ? MAXP : MINN;
      c.eye_y = $urandom;
      c.target_z = $urandom_range(1) ? MAXP : MINN;
      c.upward_y = $urandom_range(1) ? MAXP : MINN;
    end
    return c;
  endfunction

  initial begin
    cam_ch.valid = 1'b0;
    cam_ch.data  = '0;
    mat_ch.ready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase == 2 && !held) begin
        // long stall so the pipe fills and pushes back on the cameras
        held = 1'b1;
        mat_ch.ready <= 1'b0;
        repeat (399) @(negedge clk_i);
      end else begin
        mat_ch.ready <= rst_ni && ($urandom_range(99) >= rx_idle);
      end
    end
  end

  initial begin
    in_item_t dir_list [$];
    int       n;
    cameras = 0;
    phase = 0;
    tx_idle = 10;
    rx_idle = 46;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    dir_list = '{
      cam(0, 0, 0, 0, 0, 0, 0, 0, 0),
      cam(0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0),
      cam(3 << 16, -2 << 16, 7 << 16, 3 << 16, -2 << 16, 7 << 16, 0, 1 << 16, 0),
      cam(1 << 16, 2 << 16, 3 << 16, 4 << 16, 5 << 16, 6 << 16, 0, 0, 0),
      cam(0, 0, 0, 1 << 16, 2 << 16, 3 << 16, 2 << 16, 4 << 16, 6 << 16),
      cam(0, 0, 0, 1 << 16, 2 << 16, 3 << 16, -1 << 16, -2 << 16, -3 << 16),
      cam(MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP),
      cam(MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN, MINN),
      cam(MAXP, MAXP, MAXP, MINN, MINN, MINN, MAXP, MINN, MAXP),
      cam(MINN, MINN, MINN, MAXP, MAXP, MAXP, MINN, MAXP, MINN),
      cam(MINN, MAXP, MINN, MAXP, MINN, MAXP, 1, 0, 0),
      cam(MAXP, MINN, 0, MINN, MAXP, 0, 0, 0, MAXP),
      cam(0, 0, 0, 1, 0, 0, 0, 1, 0),
      cam(0, 0, 0, -1, 0, 0, 0, 0, -1),
      cam(5, 5, 5, 4, 4, 4, 1, 0, 0),
      cam(MAXP, 0, 0, MAXP - 1, 0, 0, 0, MAXP, 0),
      cam(MINN, MINN, 0, MINN, MINN, 1, MAXP, 1, 0),
      cam(-1, -1, -1, 0, 0, 0, -1, 1, -1)
    };
    foreach (dir_list[i]) send_camera(dir_list[i]);

    for (n = 0; n < 350; n++) send_camera(random_camera());
    cam_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);

    tx_idle = 46;
    rx_idle = 10;
    phase = 1;
    for (n = 0; n < 340; n++) send_camera(random_camera());

    tx_idle = 0;
    rx_idle = 0;
    phase = 2;
    for (n = 0; n < 340; n++) send_camera(random_camera());
    cam_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 20) @(negedge clk_i);
    $display("cameras sent: %0d (directed extremes, coincident eye and target,", cameras);
    $display("  zero and parallel up hints, saturating shifts); matrices checked: %0d",
             matrices);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/vmla_pkg.sv
rtl/core/vmla_in_if.sv
rtl/core/vmla_out_if.sv
rtl/core/vmla_norm.sv
rtl/core/view_matrix_from_look_at_top.sv
tb/sv/vmla_checker.sv
tb/sv/tb_top.sv
